// ----- design/sfa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sfa_pkg;

  // Ramp and feed limits.
  localparam int RAMP_LEN  = 22;
  localparam int MAX_LINES = 64;
  localparam int RAMP_W    = (RAMP_LEN > 1) ? $clog2(RAMP_LEN) : 1;
  localparam int LINE_W    = 7;
  localparam int IDLE_W    = 16;
  localparam int WAIT_W    = 16;
  localparam int COIL_W    = 4;

  localparam logic [RAMP_W-1:0] RAMP_LAST        = RAMP_W'(RAMP_LEN - 1);
  localparam logic [LINE_W-1:0] LINES_MAX        = LINE_W'(MAX_LINES);
  localparam logic [IDLE_W-1:0] IDLE_LIMIT_RESET = IDLE_W'(100);
  localparam logic [IDLE_W-1:0] IDLE_SAT         = {IDLE_W{1'b1}};
  localparam logic [WAIT_W-1:0] WAIT_CRUISE      = WAIT_W'(880);

  // Result status codes.
  localparam logic STATUS_STEP   = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_FEED = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t           opcode;
    logic [LINE_W-1:0] line_count;
    logic              direction;
    logic              head_power_on;
  } in_item_t;

  typedef struct packed {
    logic [COIL_W-1:0] coil_pattern;
    logic [WAIT_W-1:0] wait_us;
    logic              status;
    logic              last;
  } out_item_t;

  // Classified command passed from the front to the back.
  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_FEED,
    CMD_REJECT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [LINE_W-1:0] lines;
    logic              backward;
    logic              power_on;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_FEED
  } back_state_t;

  // Control decoded from the back state machine.
  typedef struct packed {
    logic cmd_pop;
    logic res_push;
    logic step;
  } back_ctrl_t;

  // Acceleration table: wait before each step of the ramp.
  function automatic logic [WAIT_W-1:0] accel_wait(input logic [RAMP_W-1:0] idx);
    logic [WAIT_W-1:0] w;
    case (idx)
      RAMP_W'(0):  w = WAIT_W'(5459);
      RAMP_W'(1):  w = WAIT_W'(3459);
      RAMP_W'(2):  w = WAIT_W'(2762);
      RAMP_W'(3):  w = WAIT_W'(2314);
      RAMP_W'(4):  w = WAIT_W'(2028);
      RAMP_W'(5):  w = WAIT_W'(1828);
      RAMP_W'(6):  w = WAIT_W'(1675);
      RAMP_W'(7):  w = WAIT_W'(1553);
      RAMP_W'(8):  w = WAIT_W'(1456);
      RAMP_W'(9):  w = WAIT_W'(1374);
      RAMP_W'(10): w = WAIT_W'(1302);
      RAMP_W'(11): w = WAIT_W'(1242);
      RAMP_W'(12): w = WAIT_W'(1191);
      RAMP_W'(13): w = WAIT_W'(1144);
      RAMP_W'(14): w = WAIT_W'(1103);
      RAMP_W'(15): w = WAIT_W'(1065);
      RAMP_W'(16): w = WAIT_W'(1031);
      RAMP_W'(17): w = WAIT_W'(1000);
      RAMP_W'(18): w = WAIT_W'(970);
      RAMP_W'(19): w = WAIT_W'(940);
      RAMP_W'(20): w = WAIT_W'(910);
      default:     w = WAIT_CRUISE;
    endcase
    return w;
  endfunction

  // Full-step coil drive for positions one through four (encoded 0..3).
  function automatic logic [COIL_W-1:0] coil_of(input logic [1:0] pos);
    logic [COIL_W-1:0] c;
    unique case (pos)
      2'd0: c = 4'h9;
      2'd1: c = 4'hA;
      2'd2: c = 4'h6;
      2'd3: c = 4'h5;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- design/sfa_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sfa_front (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  output logic             full,
  input  sfa_pkg::in_item_t in_item,
  output logic             cmd_valid,
  input  wire              cmd_ready,
  output sfa_pkg::cmd_t    cmd
);

  sfa_pkg::cmd_t cmd_in;
  sfa_pkg::cmd_t slots [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          push_ok;
  logic          pop_ok;

  // Classify the incoming transaction and clamp the line count.
  always_comb begin
    if (in_item.opcode == sfa_pkg::OP_TICK) begin
      cmd_in.kind = sfa_pkg::CMD_TICK;
    end else if (in_item.line_count == '0) begin
      cmd_in.kind = sfa_pkg::CMD_REJECT;
    end else begin
      cmd_in.kind = sfa_pkg::CMD_FEED;
    end
    cmd_in.lines    = (in_item.line_count > sfa_pkg::LINES_MAX) ? sfa_pkg::LINES_MAX
                                                                 : in_item.line_count;
    cmd_in.backward = in_item.direction;
    cmd_in.power_on = in_item.head_power_on;
  end

  // Two-entry command queue toward the back.
  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign push_ok   = push && !full;
  assign pop_ok    = cmd_valid && cmd_ready;
  assign cmd       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slots[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push_ok) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop_ok) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push_ok} - {1'b0, pop_ok};
    end
  end

endmodule

`default_nettype wire

// ----- design/sfa_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sfa_back (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         cfg_wr_en,
  input  wire [sfa_pkg::IDLE_W-1:0]   cfg_wr_data,
  input  wire                         cmd_valid,
  output logic                        cmd_ready,
  input  sfa_pkg::cmd_t               cmd,
  output logic                        empty,
  input  wire                         pop,
  output sfa_pkg::out_item_t          out_item
);

  sfa_pkg::back_state_t        state;
  sfa_pkg::back_state_t        state_next;
  sfa_pkg::back_ctrl_t         ctrl;

  logic [sfa_pkg::IDLE_W-1:0]  idle_limit;
  logic [sfa_pkg::IDLE_W-1:0]  idle_ms;
  logic [sfa_pkg::RAMP_W-1:0]  ramp_index;
  logic [sfa_pkg::RAMP_W-1:0]  ramp_next;
  logic [1:0]                  position;
  logic                        has_stepped;
  logic [sfa_pkg::LINE_W-1:0]  remaining;
  logic                        backward;
  logic                        power_on;
  logic                        restart;
  logic                        last_step;

  sfa_pkg::out_item_t          res_in;
  sfa_pkg::out_item_t          res_slots [2];
  logic                        res_wr_ptr;
  logic                        res_rd_ptr;
  logic [1:0]                  res_count;
  logic                        res_full;
  logic                        res_pop;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_limit <= sfa_pkg::IDLE_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      idle_limit <= cfg_wr_data;
    end
  end

  // Ramp update for the step about to issue.
  assign restart   = !has_stepped || ((idle_ms > idle_limit) && !power_on);
  assign last_step = (remaining == sfa_pkg::LINE_W'(1));

  always_comb begin
    if (restart) begin
      ramp_next = '0;
    end else if (ramp_index >= sfa_pkg::RAMP_LAST) begin
      ramp_next = sfa_pkg::RAMP_LAST;
    end else begin
      ramp_next = ramp_index + sfa_pkg::RAMP_W'(1);
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      sfa_pkg::BK_IDLE: begin
        if (ctrl.cmd_pop && cmd.kind == sfa_pkg::CMD_FEED) begin
          state_next = sfa_pkg::BK_FEED;
        end
      end
      sfa_pkg::BK_FEED: begin
        if (ctrl.step && last_step) begin
          state_next = sfa_pkg::BK_IDLE;
        end
      end
    endcase
  end

  // State machine outputs.
  always_comb begin
    ctrl = '0;
    unique case (state)
      sfa_pkg::BK_IDLE: begin
        ctrl.cmd_pop  = cmd_valid && (cmd.kind == sfa_pkg::CMD_TICK || !res_full);
        ctrl.res_push = ctrl.cmd_pop && (cmd.kind == sfa_pkg::CMD_REJECT);
      end
      sfa_pkg::BK_FEED: begin
        ctrl.step     = !res_full;
        ctrl.res_push = !res_full;
      end
    endcase
  end

  assign cmd_ready = ctrl.cmd_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sfa_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Motion state: idle counter, ramp position and coil phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_ms     <= '0;
      ramp_index  <= '0;
      position    <= 2'd0;
      has_stepped <= 1'b0;
      remaining   <= '0;
      backward    <= 1'b0;
      power_on    <= 1'b0;
    end else begin
      if (ctrl.cmd_pop && cmd.kind == sfa_pkg::CMD_TICK && idle_ms != sfa_pkg::IDLE_SAT) begin
        idle_ms <= idle_ms + sfa_pkg::IDLE_W'(1);
      end
      if (ctrl.cmd_pop && cmd.kind == sfa_pkg::CMD_FEED) begin
        remaining <= cmd.lines;
        backward  <= cmd.backward;
        power_on  <= cmd.power_on;
      end
      if (ctrl.step) begin
        idle_ms     <= '0;
        ramp_index  <= ramp_next;
        has_stepped <= 1'b1;
        remaining   <= remaining - sfa_pkg::LINE_W'(1);
        position    <= backward ? position - 2'd1 : position + 2'd1;
      end
    end
  end

  // Result built for this cycle: a step, or the rejection of an empty feed.
  always_comb begin
    if (state == sfa_pkg::BK_FEED) begin
      res_in.coil_pattern = sfa_pkg::coil_of(position);
      res_in.wait_us      = sfa_pkg::accel_wait(ramp_next);
      res_in.status       = sfa_pkg::STATUS_STEP;
      res_in.last         = last_step;
    end else begin
      res_in.coil_pattern = '0;
      res_in.wait_us      = '0;
      res_in.status       = sfa_pkg::STATUS_REJECT;
      res_in.last         = 1'b1;
    end
  end

  // Two-entry result queue facing the receiver.
  assign res_full = (res_count == 2'd2);
  assign empty    = (res_count == 2'd0);
  assign res_pop  = pop && !empty;
  assign out_item = res_slots[res_rd_ptr];

  always_ff @(posedge clk) begin
    if (ctrl.res_push) begin
      res_slots[res_wr_ptr] <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_wr_ptr <= 1'b0;
      res_rd_ptr <= 1'b0;
      res_count  <= 2'd0;
    end else begin
      if (ctrl.res_push) begin
        res_wr_ptr <= ~res_wr_ptr;
      end
      if (res_pop) begin
        res_rd_ptr <= ~res_rd_ptr;
      end
      res_count <= res_count + {1'b0, ctrl.res_push} - {1'b0, res_pop};
    end
  end

endmodule

`default_nettype wire

// ----- design/stepper_feed_with_accel_ramp.sv -----
// Paper-feed stepper sequencer with acceleration ramp.
//
// Input side is a queue: present an item on in_item and raise push; it is
// taken at a clock edge where full is low. A tick item counts one idle
// millisecond, a feed item asks for line_count steps (above 64 counts as 64).
// Output side is a queue: while empty is low, out_item holds the oldest
// result; raising pop takes it. Each step gives one result with the coil
// pattern and ramp wait; the final one of a feed has last set. A feed of zero
// lines gives a single result with status set.
// The idle limit register must be written through cfg_wr_en/cfg_wr_data only
// while idle; the block itself does not enforce this. A feed passes through
// the command queue and the back feed state before its first step result
// enters the result queue; a rejection enters it as the back pops the command.
// Throughput: one back sequencer step per cycle while the result queue has room.
// A two-entry command queue and a two-entry result queue decouple the sides.
// When pop stays low the result queue fills, the sequencer holds its step,
// and then the command queue fills and full rises.
// Reset (rst, synchronous) empties both queues, sets the position to the
// first phase, clears the ramp and idle count, and the limit back to 100.
`timescale 1ns / 1ps
`default_nettype none

module stepper_feed_with_accel_ramp (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        push,
  output logic                       full,
  input  sfa_pkg::in_item_t          in_item,
  output logic                       empty,
  input  wire                        pop,
  output sfa_pkg::out_item_t         out_item,
  input  wire                        cfg_wr_en,
  input  wire [sfa_pkg::IDLE_W-1:0]  cfg_wr_data
);

  logic          cmd_valid;
  logic          cmd_ready;
  sfa_pkg::cmd_t cmd;

  // Front: accepts and classifies transactions into the command queue.
  sfa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // Back: runs the step sequence and queues the results.
  sfa_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd),
    .empty       (empty),
    .pop         (pop),
    .out_item    (out_item)
  );

endmodule

`default_nettype wire

// ----- design/sfa_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sfa_checker (
  input wire                clk,
  input wire                rst,
  input wire                full,
  input wire                empty,
  input wire                pop,
  input sfa_pkg::out_item_t out_item
);

  // Both queues come out of reset empty.
  assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  // A result that is not taken stays in place.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("waiting result changed");

  // A rejected feed is a single, final, all-zero result.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && out_item.status == sfa_pkg::STATUS_REJECT) |->
      (out_item.last && out_item.coil_pattern == '0 && out_item.wait_us == '0))
    else $error("malformed rejection result");

  // A step always drives one of the four full-step patterns.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && out_item.status == sfa_pkg::STATUS_STEP) |->
      (out_item.coil_pattern == 4'h9 || out_item.coil_pattern == 4'hA ||
       out_item.coil_pattern == 4'h6 || out_item.coil_pattern == 4'h5))
    else $error("illegal coil pattern");

endmodule

bind stepper_feed_with_accel_ramp sfa_checker u_sfa_checker (
  .clk      (clk),
  .rst      (rst),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_item (out_item)
);

`default_nettype wire
